### rtl/psgi_pkg.sv
// Shared types, constants and tables of the gear indicator.
package psgi_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int GEAR_COUNT  = 6;
  localparam int GEAR_IDX_W  = $clog2(GEAR_COUNT);
  localparam int CODE_W      = 4;
  localparam int SEG_W       = 7;
  localparam int CFG_IDX_W   = 3;

  typedef logic [SAMPLE_BITS-1:0] value_t;
  typedef logic [CODE_W-1:0]      code_t;
  typedef logic [SEG_W-1:0]       seg_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

  typedef value_t pos_arr_t [GEAR_COUNT];

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_WINDOW  = 3'd0;
  localparam cfg_idx_t REG_REVERSE = 3'd1;
  localparam cfg_idx_t REG_NEUTRAL = 3'd2;
  localparam cfg_idx_t REG_FIRST   = 3'd3;
  localparam cfg_idx_t REG_SECOND  = 3'd4;
  localparam cfg_idx_t REG_THIRD   = 3'd5;
  localparam cfg_idx_t REG_FOURTH  = 3'd6;

  // Gear codes as shown
  localparam code_t GEAR_NEUTRAL = 4'd0;
  localparam code_t GEAR_FIRST   = 4'd1;
  localparam code_t GEAR_SECOND  = 4'd2;
  localparam code_t GEAR_THIRD   = 4'd3;
  localparam code_t GEAR_FOURTH  = 4'd4;
  localparam code_t GEAR_REVERSE = 4'd11;

  localparam seg_t SEG_BLANK = 7'h7F;

  localparam value_t WINDOW_RESET = value_t'(25);

  // Table order: reverse, neutral, first .. fourth
  localparam value_t POS_RESET [GEAR_COUNT] = '{
    value_t'(500), value_t'(418), value_t'(336),
    value_t'(256), value_t'(176), value_t'(100)
  };

  localparam code_t GEAR_CODES [GEAR_COUNT] = '{
    GEAR_REVERSE, GEAR_NEUTRAL, GEAR_FIRST, GEAR_SECOND, GEAR_THIRD, GEAR_FOURTH
  };

  // Active-low patterns, bit0 = a .. bit6 = g
  localparam seg_t GEAR_SEGS [GEAR_COUNT] = '{
    7'h2F, 7'h40, 7'h79, 7'h24, 7'h30, 7'h19
  };

  typedef struct packed {
    logic  hit;
    code_t code;
    seg_t  segs;
  } match_t;

endpackage

### rtl/psgi_match.sv
// Window compare of the smoothed value against the six gear positions.
module psgi_match (
  input  psgi_pkg::value_t   smoothed,
  input  psgi_pkg::value_t   window,
  input  psgi_pkg::pos_arr_t positions,
  output psgi_pkg::match_t   match
);
  import psgi_pkg::*;

  value_t             gap [GEAR_COUNT];
  logic [GEAR_COUNT-1:0] in_win;

  always_comb begin
    for (int i = 0; i < GEAR_COUNT; i++) begin
      gap[i]    = (smoothed >= positions[i]) ? value_t'(smoothed - positions[i])
                                             : value_t'(positions[i] - smoothed);
      in_win[i] = (gap[i] <= window);
    end
  end

  // Last matching entry in table order wins
  always_comb begin
    match.hit  = 1'b0;
    match.code = GEAR_NEUTRAL;
    match.segs = SEG_BLANK;
    for (int i = 0; i < GEAR_COUNT; i++) begin
      if (in_win[i]) begin
        match.hit  = 1'b1;
        match.code = GEAR_CODES[i];
        match.segs = GEAR_SEGS[i];
      end
    end
  end

endmodule

### rtl/position_sensor_gear_indicator.sv
// Top level of the shift-lever gear indicator.
//
// Takes one lever position sample per transfer and returns one result per
// sample: the smoothed position floor((3*old + 2*sample)/5), the shown gear
// code (0 neutral, 1..4 gears, 11 reverse), its active-low seven-segment
// pattern and a flag that is set when this sample changed the shown gear.
// A gear is taken when the smoothed value lies within match_window of its
// configured position; when several match, the last in the order reverse,
// neutral, first..fourth wins. After reset the display is blank (all
// segments high) with neutral shown, until another gear latches.
// Throughput is one sample per clock while the result side is not stalled; a
// sample passes through the input register, then the result register. The smoothing
// divide, the six window compares and the segment lookup all sit in the
// combinational logic between those two registers, since the running average must
// be ready for the next sample. Configuration is taken at any cycle
// (cfg_ready is always high) and should be written while the block is idle.
module position_sensor_gear_indicator (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  psgi_pkg::value_t              in_sample,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output psgi_pkg::seg_t                out_segments,
  output psgi_pkg::code_t               out_gear_code,
  output logic                          out_changed,
  output psgi_pkg::value_t              out_smoothed,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  psgi_pkg::cfg_idx_t            cfg_index,
  input  psgi_pkg::value_t              cfg_data
);
  import psgi_pkg::*;

  // Divide by five as multiply by a rounded-up reciprocal and shift. With
  // the shift two bits past the sum width the error stays below 1/5.
  localparam int SUM_W   = SAMPLE_BITS + 3;
  localparam int DIV_SH  = SUM_W + 2;
  localparam int RECIP_W = SUM_W;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'(((64'd1 << DIV_SH) + 64'd4) / 64'd5);

  // configuration registers
  value_t   window_r;
  pos_arr_t pos_r;

  // input stage
  logic   s1_valid_r;
  value_t s1_sample_r;

  // state, which also drives the result payload
  value_t avg_r;
  code_t  gear_r;
  seg_t   seg_r;
  logic   changed_r;
  logic   out_valid_r;

  logic             out_free;
  logic             s1_load;
  logic             s1_adv;
  logic [SUM_W-1:0] sum;
  logic [PROD_W-1:0] prod;
  value_t           avg_nxt;
  match_t           match;
  logic             latch;

  assign cfg_ready = 1'b1;

  // Hold a result while the far side stalls; the input stage refills as
  // soon as its item moves on.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign s1_load  = in_valid && !in_stall;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      pos_r    <= POS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == REG_WINDOW) begin
        window_r <= cfg_data;
      end else if (cfg_index <= REG_FOURTH) begin
        pos_r[GEAR_IDX_W'(cfg_index - REG_REVERSE)] <= cfg_data;
      end else begin
        // drop writes to unknown indexes
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_sample_r <= in_sample;
    end
  end

  // Exponential average, 3/5 old and 2/5 new, truncated
  assign sum     = SUM_W'({avg_r, 1'b0}) + SUM_W'(avg_r) + SUM_W'({s1_sample_r, 1'b0});
  assign prod    = PROD_W'(sum) * PROD_W'(RECIP5);
  assign avg_nxt = prod[DIV_SH +: SAMPLE_BITS];

  psgi_match u_match (
    .smoothed  (avg_nxt),
    .window    (window_r),
    .positions (pos_r),
    .match     (match)
  );

  assign latch = match.hit && (match.code != gear_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      avg_r       <= '0;
      gear_r      <= GEAR_NEUTRAL;
      seg_r       <= SEG_BLANK;
      changed_r   <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        avg_r       <= avg_nxt;
        changed_r   <= latch;
        if (latch) begin
          gear_r <= match.code;
          seg_r  <= match.segs;
        end
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_segments  = seg_r;
  assign out_gear_code = gear_r;
  assign out_changed   = changed_r;
  assign out_smoothed  = avg_r;

endmodule
